// File: src/spq_pkg.sv
// Shared types and constants for the sorted priority task queue.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Field widths of the input and result words.
  localparam int ID_BITS       = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int ACTION_BITS   = 2;
  localparam int STATUS_BITS   = 3;
  localparam int POS_BITS      = 4;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;
  localparam int LIMIT_BITS    = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIORITY_MODE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_LIMIT   = 1'd1;

  localparam logic                  MODE_RESET  = 1'b1;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  // Action codes of the input word.
  localparam logic [ACTION_BITS-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_LIST   = 2'd2;

  // Status codes of the result word.
  localparam logic [STATUS_BITS-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_ENTRY     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [ACTION_BITS-1:0]   action;
    logic [ID_BITS-1:0]       task_id;
    logic [PRIORITY_BITS-1:0] task_priority;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]   status;
    logic [ID_BITS-1:0]       entry_id;
    logic [PRIORITY_BITS-1:0] entry_priority;
    logic [POS_BITS-1:0]      entry_position;
    logic                     last;
  } out_word_t;

  // Operation class decided by the front end.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_LIST,
    OP_NOP
  } op_t;

  // One classified word waiting between front and back.
  typedef struct packed {
    op_t                      op;
    logic [ID_BITS-1:0]       task_id;
    logic [PRIORITY_BITS-1:0] task_priority;
  } q_item_t;

  // Command from the sequencer to the entry table.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic                     mode;
    logic [ID_BITS-1:0]       key;
    logic [PRIORITY_BITS-1:0] pri;
  } tbl_cmd_t;

endpackage

`default_nettype wire

// File: src/sorted_priority_task_queue.sv
// Sorted priority task queue: front queue, sequencer and entry table cells.
// A word accepted into the front queue gives its first result word from the output register.
// Throughput: one add, remove or unused action per cycle while out_stall is low;
// a list walks the stored entries in turn (an empty table gives one EMPTY word).
// Reset clears the entry count, priority_mode to 1 and queue_limit to 16;
// the cells need no clearing pass. Depends on spq_pkg, spq_front, spq_table, spq_back.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_task_queue #(
  parameter int DEPTH = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [spq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [spq_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  spq_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  wire                               out_stall,
  output spq_pkg::out_word_t                out_word
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                     q_valid;
  q_item_t                  q_item;
  logic                     q_pop;
  tbl_cmd_t                 cmd;
  logic [AW-1:0]            rd_addr;
  logic [ID_BITS-1:0]       rd_id;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic                     found;
  logic [CW-1:0]            count;

  // Accept and classify input words.
  spq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Sequence the table and build result words.
  spq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .rd_id     (rd_id),
    .rd_pri    (rd_pri),
    .found     (found),
    .count     (count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Ordered entry cells.
  spq_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_pri  (rd_pri),
    .found   (found),
    .count   (count)
  );

endmodule

`default_nettype wire

// File: src/spq_front.sv
// Front end: accepts input words, classifies the action and holds them in a
// two-entry queue for the back end. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  spq_pkg::in_word_t   in_word,
  output logic                q_valid,
  output spq_pkg::q_item_t    q_item,
  input  wire                 q_pop
);
  import spq_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QFW    = $clog2(QDEPTH + 1);

  q_item_t            slot_r [QDEPTH];
  logic [QPW-1:0]     wptr_r, wptr_nxt;
  logic [QPW-1:0]     rptr_r, rptr_nxt;
  logic [QFW-1:0]     fill_r, fill_nxt;
  logic               push;
  q_item_t            item_new;

  // Classify the incoming action.
  always_comb begin
    item_new.task_id       = in_word.task_id;
    item_new.task_priority = in_word.task_priority;
    unique case (in_word.action)
      ACT_ADD:    item_new.op = OP_ADD;
      ACT_REMOVE: item_new.op = OP_REMOVE;
      ACT_LIST:   item_new.op = OP_LIST;
      default:    item_new.op = OP_NOP;
    endcase
  end

  assign in_stall = (fill_r == QFW'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign q_item   = slot_r[rptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_nxt = push ? wptr_r + QPW'(1) : wptr_r;
    rptr_nxt = q_pop ? rptr_r + QPW'(1) : rptr_r;
    fill_nxt = fill_r;
    if (push && !q_pop) begin
      fill_nxt = fill_r + QFW'(1);
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - QFW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= item_new;
    end
  end

endmodule

`default_nettype wire

// File: src/spq_table.sv
// Entry table: a row of id/priority cells that insert or delete one entry per
// cycle by shifting neighbors, plus one read port for listing. Uses spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_table #(
  parameter int DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  spq_pkg::tbl_cmd_t                    cmd,
  input  wire  [$clog2(DEPTH)-1:0]             rd_addr,
  output logic [spq_pkg::ID_BITS-1:0]          rd_id,
  output logic [spq_pkg::PRIORITY_BITS-1:0]    rd_pri,
  output logic                                 found,
  output logic [$clog2(DEPTH+1)-1:0]           count
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [ID_BITS-1:0]       id_r  [DEPTH];
  logic [ID_BITS-1:0]       id_nxt [DEPTH];
  logic [PRIORITY_BITS-1:0] pri_r [DEPTH];
  logic [PRIORITY_BITS-1:0] pri_nxt [DEPTH];
  logic [CW-1:0]            count_r, count_nxt;

  logic [DEPTH-1:0] ge;     // valid cell that stays ahead of a new entry
  logic [DEPTH-1:0] hi;     // some ge cell at this position or behind it
  logic [DEPTH-1:0] match;  // valid cell holding the key
  logic [DEPTH-1:0] pre;    // a match lies strictly ahead of this cell

  // Per-cell compare flags.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i]    = (CW'(i) < count_r) && (!cmd.mode || (pri_r[i] >= cmd.pri));
      match[i] = (CW'(i) < count_r) && (id_r[i] == cmd.key);
    end
  end

  // Suffix and prefix OR chains locate the insert and delete points.
  always_comb begin
    hi[DEPTH-1] = ge[DEPTH-1];
    for (int i = DEPTH - 2; i >= 0; i--) begin
      hi[i] = hi[i+1] | ge[i];
    end
    pre[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) begin
      pre[i] = pre[i-1] | match[i-1];
    end
  end

  assign found = pre[DEPTH-1] | match[DEPTH-1];
  assign count = count_r;
  assign rd_id  = id_r[rd_addr];
  assign rd_pri = pri_r[rd_addr];

  // Next cell contents: insert opens a gap, delete closes one.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      id_nxt[i]  = id_r[i];
      pri_nxt[i] = pri_r[i];
    end
    if (cmd.ins) begin
      if (!hi[0]) begin
        id_nxt[0]  = cmd.key;
        pri_nxt[0] = cmd.pri;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (hi[i-1] && !hi[i]) begin
          id_nxt[i]  = cmd.key;
          pri_nxt[i] = cmd.pri;
        end else if (!hi[i-1]) begin
          id_nxt[i]  = id_r[i-1];
          pri_nxt[i] = pri_r[i-1];
        end
      end
    end else if (cmd.rem && found) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (pre[i] || match[i]) begin
          id_nxt[i]  = id_r[i+1];
          pri_nxt[i] = pri_r[i+1];
        end
      end
    end
  end

  // Entry count follows the command.
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rem && found) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Cells carry payload only; unused slots are never read.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      id_r[i]  <= id_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
  end

endmodule

`default_nettype wire

// File: src/spq_back.sv
// Back end: configuration registers, the sequencer that drives the entry
// table, and the output word register. Uses spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_back #(
  parameter int DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [spq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire  [spq_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  wire                                  q_valid,
  input  spq_pkg::q_item_t                     q_item,
  output logic                                 q_pop,
  output spq_pkg::tbl_cmd_t                    cmd,
  output logic [$clog2(DEPTH)-1:0]             rd_addr,
  input  wire  [spq_pkg::ID_BITS-1:0]          rd_id,
  input  wire  [spq_pkg::PRIORITY_BITS-1:0]    rd_pri,
  input  wire                                  found,
  input  wire  [$clog2(DEPTH+1)-1:0]           count,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output spq_pkg::out_word_t                   out_word
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  typedef enum logic {
    S_RUN,
    S_LIST
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  mode_r, mode_nxt;
  logic [LIMIT_BITS-1:0] limit_r, limit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;
  logic                  out_ok;
  logic                  full;
  logic                  list_last;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_ok    = !out_valid_r || !out_stall;

  // Adds are refused at the configured limit or at the table depth.
  assign full = (LW'(count) >= LW'(limit_r)) || (LW'(count) >= LW'(DEPTH));
  assign list_last = ((CW'(idx_r) + CW'(1)) == count);
  assign rd_addr = (state_r == S_LIST) ? idx_r : '0;

  // Configuration writes.
  always_comb begin
    mode_nxt  = mode_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRIORITY_MODE: mode_nxt  = cfg_wdata[0];
        CFG_QUEUE_LIMIT:   limit_nxt = cfg_wdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: one word per cycle while out_stall is low, a list walks the table one entry a cycle.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    cmd.ins       = 1'b0;
    cmd.rem       = 1'b0;
    cmd.mode      = mode_r;
    cmd.key       = q_item.task_id;
    cmd.pri       = q_item.task_priority;
    unique case (state_r)
      S_RUN: begin
        if (q_valid && out_ok) begin
          q_pop              = 1'b1;
          out_valid_nxt      = 1'b1;
          out_word_nxt       = '0;
          out_word_nxt.last  = 1'b1;
          unique case (q_item.op)
            OP_ADD: begin
              if (full) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                cmd.ins             = 1'b1;
                out_word_nxt.status = ST_DONE;
              end
            end
            OP_REMOVE: begin
              cmd.rem             = 1'b1;
              out_word_nxt.status = found ? ST_DONE : ST_NOT_FOUND;
            end
            OP_LIST: begin
              if (count == '0) begin
                out_word_nxt.status = ST_EMPTY;
              end else begin
                out_word_nxt.status         = ST_ENTRY;
                out_word_nxt.entry_id       = rd_id;
                out_word_nxt.entry_priority = rd_pri;
                out_word_nxt.last           = (count == CW'(1));
                if (count != CW'(1)) begin
                  state_nxt = S_LIST;
                  idx_nxt   = AW'(1);
                end
              end
            end
            default: begin
              out_word_nxt.status = ST_DONE;
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_ok) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.status         = ST_ENTRY;
          out_word_nxt.entry_id       = rd_id;
          out_word_nxt.entry_priority = rd_pri;
          out_word_nxt.entry_position = POS_BITS'(idx_r);
          out_word_nxt.last           = list_last;
          idx_nxt                     = idx_r + AW'(1);
          if (list_last) begin
            state_nxt = S_RUN;
          end
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      idx_r       <= '0;
      mode_r      <= MODE_RESET;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      mode_r      <= mode_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire
